FILE: sv/lr_pkg.sv
// Shared constants for the line rasterizer.
package lr_pkg;

   // default coordinate width, in bits
   localparam int COORD_BITS_DEFAULT = 12;
   // width of one color component
   localparam int COLOR_BITS = 8;
   // depth of the queues between stages
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   // item kinds
   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_STEP = 1'b1;

endpackage

FILE: sv/lr_fifo.sv
// Small register queue with fall-through read, used between stages.
module lr_fifo
   import lr_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);
   localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(DEPTH - 1);
   localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(DEPTH);

   logic [WIDTH-1:0]    entry_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                do_push, do_pop;

   assign full     = (count_ff == FULL_CNT);
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   // advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store the pushed beat
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: sv/lr_front.sv
// Front stage: classify items and compute line setup for loads.
module lr_front
   import lr_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEFAULT,
   parameter int CMD_BITS   = 7 * COORD_BITS + 5 + 3 * COLOR_BITS
) (
   input  logic                  kind,
   input  logic [COORD_BITS-1:0] start_x,
   input  logic [COORD_BITS-1:0] start_y,
   input  logic [COORD_BITS-1:0] end_x,
   input  logic [COORD_BITS-1:0] end_y,
   input  logic [COLOR_BITS-1:0] red,
   input  logic [COLOR_BITS-1:0] green,
   input  logic [COLOR_BITS-1:0] blue,
   output logic [CMD_BITS-1:0]   cmd
);

   localparam int ERR_BITS = COORD_BITS + 2;

   logic                  x_fwd, y_fwd;
   logic [COORD_BITS-1:0] span_x, span_y;
   logic [ERR_BITS-1:0]   err_init;

   // step direction and absolute deltas
   assign x_fwd  = start_x < end_x;
   assign y_fwd  = start_y < end_y;
   assign span_x = x_fwd ? end_x - start_x : start_x - end_x;
   assign span_y = y_fwd ? end_y - start_y : start_y - end_y;

   // initial error is span_x - span_y
   assign err_init = ERR_BITS'({2'b00, span_x}) - ERR_BITS'({2'b00, span_y});

   // pack the command beat
   assign cmd = {kind, start_x, start_y, end_x, end_y, span_x, span_y,
                 !x_fwd, !y_fwd, err_init, red, green, blue};

endmodule

FILE: sv/lr_back.sv
// Back stage: hold the line state and walk pixels one per step.
module lr_back
   import lr_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEFAULT,
   parameter int CMD_BITS   = 7 * COORD_BITS + 5 + 3 * COLOR_BITS,
   parameter int RSP_BITS   = 2 * COORD_BITS + 1 + 3 * COLOR_BITS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [CMD_BITS-1:0] cmd,
   input  logic                cmd_empty,
   output logic                cmd_pop,
   output logic [RSP_BITS-1:0] rsp,
   output logic                rsp_push,
   input  logic                rsp_full
);

   localparam int ERR_BITS = COORD_BITS + 2;
   localparam int E2_BITS  = COORD_BITS + 3;

   // unpacked command
   logic                  c_kind;
   logic [COORD_BITS-1:0] c_sx, c_sy, c_ex, c_ey, c_span_x, c_span_y;
   logic                  c_xneg, c_yneg;
   logic [ERR_BITS-1:0]   c_err;
   logic [COLOR_BITS-1:0] c_red, c_green, c_blue;

   // line state
   logic [COORD_BITS-1:0] cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic [COORD_BITS-1:0] tgt_x_ff, tgt_x_in, tgt_y_ff, tgt_y_in;
   logic [COORD_BITS-1:0] span_x_ff, span_x_in, span_y_ff, span_y_in;
   logic                  xneg_ff, xneg_in, yneg_ff, yneg_in;
   logic [ERR_BITS-1:0]   err_ff, err_in;
   logic [COLOR_BITS-1:0] red_ff, red_in, green_ff, green_in, blue_ff, blue_in;
   logic                  pending_ff, pending_in, active_ff, active_in;

   // walk datapath
   logic signed [E2_BITS-1:0] e2, dx, dy, err_x;
   logic                      move_x, move_y;
   logic [COORD_BITS-1:0]     nx, ny, px, py;
   logic                      only, fin, res_last;

   assign {c_kind, c_sx, c_sy, c_ex, c_ey, c_span_x, c_span_y,
           c_xneg, c_yneg, c_err, c_red, c_green, c_blue} = cmd;

   // take a command whenever a result slot is free
   assign cmd_pop = !cmd_empty && !rsp_full;

   // doubled error against the deltas
   assign e2     = $signed({err_ff, 1'b0});
   assign dx     = $signed(E2_BITS'({3'b000, span_x_ff}));
   assign dy     = $signed(E2_BITS'({3'b000, span_y_ff}));
   assign move_x = e2 > -dy;
   assign move_y = e2 < dx;
   assign err_x  = $signed({err_ff[ERR_BITS-1], err_ff})
                   - (move_x ? dy : E2_BITS'(0))
                   + (move_y ? dx : E2_BITS'(0));
   assign nx     = move_x ? (xneg_ff ? cur_x_ff - 1'b1 : cur_x_ff + 1'b1) : cur_x_ff;
   assign ny     = move_y ? (yneg_ff ? cur_y_ff - 1'b1 : cur_y_ff + 1'b1) : cur_y_ff;
   assign only   = (cur_x_ff == tgt_x_ff) && (cur_y_ff == tgt_y_ff);
   assign fin    = (nx == tgt_x_ff) && (ny == tgt_y_ff);

   // apply one command beat
   always_comb begin
      cur_x_in   = cur_x_ff;
      cur_y_in   = cur_y_ff;
      tgt_x_in   = tgt_x_ff;
      tgt_y_in   = tgt_y_ff;
      span_x_in  = span_x_ff;
      span_y_in  = span_y_ff;
      xneg_in    = xneg_ff;
      yneg_in    = yneg_ff;
      err_in     = err_ff;
      red_in     = red_ff;
      green_in   = green_ff;
      blue_in    = blue_ff;
      pending_in = pending_ff;
      active_in  = active_ff;
      rsp_push   = 1'b0;
      px         = cur_x_ff;
      py         = cur_y_ff;
      res_last   = fin;
      if (cmd_pop) begin
         if (c_kind == KIND_LOAD) begin
            cur_x_in   = c_sx;
            cur_y_in   = c_sy;
            tgt_x_in   = c_ex;
            tgt_y_in   = c_ey;
            span_x_in  = c_span_x;
            span_y_in  = c_span_y;
            xneg_in    = c_xneg;
            yneg_in    = c_yneg;
            err_in     = c_err;
            red_in     = c_red;
            green_in   = c_green;
            blue_in    = c_blue;
            pending_in = 1'b1;
            active_in  = 1'b1;
         end else if (active_ff) begin
            rsp_push = 1'b1;
            if (pending_ff) begin
               // end point first
               px         = tgt_x_ff;
               py         = tgt_y_ff;
               res_last   = only;
               pending_in = 1'b0;
               active_in  = !only;
            end else begin
               cur_x_in  = nx;
               cur_y_in  = ny;
               err_in    = ERR_BITS'(err_x);
               active_in = !fin;
            end
         end
      end
   end

   assign rsp = {px, py, red_ff, green_ff, blue_ff, res_last};

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 1'b0;
         active_ff  <= 1'b0;
      end else begin
         pending_ff <= pending_in;
         active_ff  <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_x_ff  <= cur_x_in;
      cur_y_ff  <= cur_y_in;
      tgt_x_ff  <= tgt_x_in;
      tgt_y_ff  <= tgt_y_in;
      span_x_ff <= span_x_in;
      span_y_ff <= span_y_in;
      xneg_ff   <= xneg_in;
      yneg_ff   <= yneg_in;
      err_ff    <= err_in;
      red_ff    <= red_in;
      green_ff  <= green_in;
      blue_ff   <= blue_in;
   end

endmodule

FILE: sv/line_rasterizer.sv
// Line rasterizer top level: front setup, command queue, pixel walker, result queue.
// A step beat is held in the command queue, then the result queue, before rsp_ shows it.
// Throughput: one item per cycle; the walker retires one beat per cycle unless rsp_full.
// Each item fits one pass of the walker's add/compare path, so loads and steps mix freely.
// Reset (synchronous, active high) empties both queues and leaves no line active.
module line_rasterizer
   import lr_pkg::*;
#(
   parameter int COORD_BITS  = COORD_BITS_DEFAULT,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  logic                  req_kind,
   input  logic [COORD_BITS-1:0] req_start_x,
   input  logic [COORD_BITS-1:0] req_start_y,
   input  logic [COORD_BITS-1:0] req_end_x,
   input  logic [COORD_BITS-1:0] req_end_y,
   input  logic [COLOR_BITS-1:0] req_red,
   input  logic [COLOR_BITS-1:0] req_green,
   input  logic [COLOR_BITS-1:0] req_blue,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output logic [COORD_BITS-1:0] rsp_pixel_x,
   output logic [COORD_BITS-1:0] rsp_pixel_y,
   output logic [COLOR_BITS-1:0] rsp_out_red,
   output logic [COLOR_BITS-1:0] rsp_out_green,
   output logic [COLOR_BITS-1:0] rsp_out_blue,
   output logic                  rsp_last
);

   localparam int CMD_BITS = 7 * COORD_BITS + 5 + 3 * COLOR_BITS;
   localparam int RSP_BITS = 2 * COORD_BITS + 1 + 3 * COLOR_BITS;

   logic [CMD_BITS-1:0] cmd_in, cmd_out;
   logic                cmd_empty, cmd_pop;
   logic [RSP_BITS-1:0] rsp_in, rsp_out;
   logic                rsp_push, rsp_full;

   // classify and set up
   lr_front #(
      .COORD_BITS(COORD_BITS),
      .CMD_BITS  (CMD_BITS)
   ) u_front (
      .kind   (req_kind),
      .start_x(req_start_x),
      .start_y(req_start_y),
      .end_x  (req_end_x),
      .end_y  (req_end_y),
      .red    (req_red),
      .green  (req_green),
      .blue   (req_blue),
      .cmd    (cmd_in)
   );

   // command queue between front and back
   lr_fifo #(
      .WIDTH(CMD_BITS),
      .DEPTH(QUEUE_DEPTH)
   ) u_cmd_q (
      .clock    (clock),
      .reset    (reset),
      .push     (req_push),
      .push_data(cmd_in),
      .full     (req_full),
      .pop      (cmd_pop),
      .pop_data (cmd_out),
      .empty    (cmd_empty)
   );

   // walk pixels
   lr_back #(
      .COORD_BITS(COORD_BITS),
      .CMD_BITS  (CMD_BITS),
      .RSP_BITS  (RSP_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd_out),
      .cmd_empty(cmd_empty),
      .cmd_pop  (cmd_pop),
      .rsp      (rsp_in),
      .rsp_push (rsp_push),
      .rsp_full (rsp_full)
   );

   // result queue toward the consumer
   lr_fifo #(
      .WIDTH(RSP_BITS),
      .DEPTH(QUEUE_DEPTH)
   ) u_rsp_q (
      .clock    (clock),
      .reset    (reset),
      .push     (rsp_push),
      .push_data(rsp_in),
      .full     (rsp_full),
      .pop      (rsp_pop),
      .pop_data (rsp_out),
      .empty    (rsp_empty)
   );

   assign {rsp_pixel_x, rsp_pixel_y, rsp_out_red, rsp_out_green, rsp_out_blue,
           rsp_last} = rsp_out;

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for the line rasterizer: directed and random line walks.
`timescale 1ns / 100ps

module testbench;
   import lr_pkg::*;

   localparam int CW         = COORD_BITS_DEFAULT;
   localparam int CMAX       = (1 << CW) - 1;
   localparam int ITEM_GOAL  = 1100;
   localparam int PHASE_LEN  = 140;
   localparam int STALL_CAP  = 2000;
   localparam int DRAIN_WAIT = 8;

   typedef struct packed {
      logic                  kind;
      logic [CW-1:0]         start_x;
      logic [CW-1:0]         start_y;
      logic [CW-1:0]         end_x;
      logic [CW-1:0]         end_y;
      logic [COLOR_BITS-1:0] red;
      logic [COLOR_BITS-1:0] green;
      logic [COLOR_BITS-1:0] blue;
   } line_beat_type;

   typedef struct packed {
      logic [CW-1:0]         x;
      logic [CW-1:0]         y;
      logic [COLOR_BITS-1:0] red;
      logic [COLOR_BITS-1:0] green;
      logic [COLOR_BITS-1:0] blue;
      logic                  last;
   } pixel_type;

   // Walks lines the same way the block does and holds the pixels still owed.
   class LinePixelPredictor;
      logic [CW-1:0] walk_x, walk_y, dest_x, dest_y, span_x, span_y;
      bit            dec_x, dec_y;
      int            err;
      logic [23:0]   color;
      bit            endpoint_due, drawing;
      pixel_type     expected_pixels[$];
      int            mismatches;

      function new();
         walk_x = '0; walk_y = '0; dest_x = '0; dest_y = '0;
         span_x = '0; span_y = '0;
         dec_x = 0; dec_y = 0; err = 0; color = '0;
         endpoint_due = 0; drawing = 0;
         mismatches = 0;
      endfunction

      // Update the line state for one accepted beat and queue its pixel, if any.
      function void take_beat(line_beat_type b);
         pixel_type px;
         int        e2;
         bit        fin;
         if (b.kind == KIND_LOAD) begin
            walk_x = b.start_x;
            walk_y = b.start_y;
            dest_x = b.end_x;
            dest_y = b.end_y;
            dec_x  = !(b.start_x < b.end_x);
            dec_y  = !(b.start_y < b.end_y);
            span_x = dec_x ? b.start_x - b.end_x : b.end_x - b.start_x;
            span_y = dec_y ? b.start_y - b.end_y : b.end_y - b.start_y;
            err    = int'(span_x) - int'(span_y);
            color  = {b.red, b.green, b.blue};
            endpoint_due = 1;
            drawing      = 1;
         end else if (drawing) begin
            if (endpoint_due) begin
               // the end point goes out first
               fin = (walk_x == dest_x) && (walk_y == dest_y);
               endpoint_due = 0;
               px = '{dest_x, dest_y, color[23:16], color[15:8], color[7:0], fin};
            end else begin
               px = '{walk_x, walk_y, color[23:16], color[15:8], color[7:0], 1'b0};
               e2 = 2 * err;
               if (e2 > -int'(span_y)) begin
                  err    = err - int'(span_y);
                  walk_x = dec_x ? walk_x - 1'b1 : walk_x + 1'b1;
               end
               if (e2 < int'(span_x)) begin
                  err    = err + int'(span_x);
                  walk_y = dec_y ? walk_y - 1'b1 : walk_y + 1'b1;
               end
               fin = (walk_x == dest_x) && (walk_y == dest_y);
               px.last = fin;
            end
            if (fin)
               drawing = 0;
            expected_pixels.push_back(px);
         end
      endfunction

      function void check_field(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            mismatches++;
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
         end
      endfunction

      // Compare one popped pixel with the oldest one owed.
      function void check_pixel(pixel_type got);
         pixel_type want;
         if (expected_pixels.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected pixel: expected none, got x=%0d y=%0d last=%0d",
                     $time, got.x, got.y, got.last);
         end else begin
            want = expected_pixels.pop_front();
            check_field("pixel_x", want.x, got.x);
            check_field("pixel_y", want.y, got.y);
            check_field("out_red", want.red, got.red);
            check_field("out_green", want.green, got.green);
            check_field("out_blue", want.blue, got.blue);
            check_field("last", want.last, got.last);
         end
      endfunction

      function int pending();
         return expected_pixels.size();
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_push = 1'b0;
   logic                  req_full;
   logic                  req_kind = 1'b0;
   logic [CW-1:0]         req_start_x = '0;
   logic [CW-1:0]         req_start_y = '0;
   logic [CW-1:0]         req_end_x = '0;
   logic [CW-1:0]         req_end_y = '0;
   logic [COLOR_BITS-1:0] req_red = '0;
   logic [COLOR_BITS-1:0] req_green = '0;
   logic [COLOR_BITS-1:0] req_blue = '0;
   logic                  rsp_empty;
   logic                  rsp_pop = 1'b0;
   logic [CW-1:0]         rsp_pixel_x;
   logic [CW-1:0]         rsp_pixel_y;
   logic [COLOR_BITS-1:0] rsp_out_red;
   logic [COLOR_BITS-1:0] rsp_out_green;
   logic [COLOR_BITS-1:0] rsp_out_blue;
   logic                  rsp_last;

   LinePixelPredictor predictor = new();

   // idle and stall rates per phase: none, sender only, receiver only, both lightly
   int send_idle_by_phase[4] = '{0, 47, 0, 7};
   int pop_stall_by_phase[4] = '{0, 0, 47, 7};
   int send_idle_pct = 0;
   int pop_stall_pct = 0;
   int items_sent    = 0;
   int quiet_cycles  = 0;

   line_rasterizer u_top (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_kind      (req_kind),
      .req_start_x   (req_start_x),
      .req_start_y   (req_start_y),
      .req_end_x     (req_end_x),
      .req_end_y     (req_end_y),
      .req_red       (req_red),
      .req_green     (req_green),
      .req_blue      (req_blue),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_pixel_x   (rsp_pixel_x),
      .rsp_pixel_y   (rsp_pixel_y),
      .rsp_out_red   (rsp_out_red),
      .rsp_out_green (rsp_out_green),
      .rsp_out_blue  (rsp_out_blue),
      .rsp_last      (rsp_last)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Stall the result side at the current phase's rate.
   always @(posedge clock) begin
      rsp_pop <= (int'($urandom_range(99)) >= pop_stall_pct);
   end

   // Note accepted beats, check popped pixels, and watch for a hang.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_push && !req_full)
            predictor.take_beat('{req_kind, req_start_x, req_start_y, req_end_x, req_end_y,
                                  req_red, req_green, req_blue});
         if (rsp_pop && !rsp_empty)
            predictor.check_pixel('{rsp_pixel_x, rsp_pixel_y, rsp_out_red, rsp_out_green,
                                    rsp_out_blue, rsp_last});
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_CAP) begin
            $display("%0t: no beat moved for %0d cycles", $time, STALL_CAP);
            $display("line_rasterizer regression: fail");
            $finish;
         end
      end
   end

   function automatic line_beat_type random_beat();
      line_beat_type b;
      b.kind    = 1'($urandom_range(1));
      b.start_x = CW'($urandom);
      b.start_y = CW'($urandom);
      b.end_x   = CW'($urandom);
      b.end_y   = CW'($urandom);
      b.red     = COLOR_BITS'($urandom);
      b.green   = COLOR_BITS'($urandom);
      b.blue    = COLOR_BITS'($urandom);
      return b;
   endfunction

   // Pick an end coordinate a given span away from the start, staying on the grid.
   function automatic int near_coord(int s, int span);
      bit up;
      int e;
      up = 1'($urandom_range(1));
      e  = up ? s + span : s - span;
      if (e < 0 || e > CMAX)
         e = up ? s - span : s + span;
      return e;
   endfunction

   // Offer one beat after a random idle stretch; return once it is accepted.
   task automatic send_beat(input line_beat_type b);
      while (int'($urandom_range(99)) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push    <= 1'b1;
      req_kind    <= b.kind;
      req_start_x <= b.start_x;
      req_start_y <= b.start_y;
      req_end_x   <= b.end_x;
      req_end_y   <= b.end_y;
      req_red     <= b.red;
      req_green   <= b.green;
      req_blue    <= b.blue;
      do @(posedge clock); while (req_full);
      items_sent++;
      send_idle_pct = send_idle_by_phase[(items_sent / PHASE_LEN) % 4];
      pop_stall_pct = pop_stall_by_phase[(items_sent / PHASE_LEN) % 4];
   endtask

   // Step beats carry random junk in the ignored fields.
   task automatic send_step();
      line_beat_type b;
      b      = random_beat();
      b.kind = KIND_STEP;
      send_beat(b);
   endtask

   // Load one line, then ask for a number of pixels.
   task automatic do_line(input int sx, input int sy, input int ex, input int ey,
                          input logic [23:0] rgb, input int steps);
      line_beat_type b;
      b.kind    = KIND_LOAD;
      b.start_x = CW'(sx);
      b.start_y = CW'(sy);
      b.end_x   = CW'(ex);
      b.end_y   = CW'(ey);
      {b.red, b.green, b.blue} = rgb;
      send_beat(b);
      repeat (steps) send_step();
   endtask

   initial begin
      int pick, sx, sy, ex, ey, len, steps, tweak;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // step with no line loaded
      send_step();
      // single point, then a step after the line is done
      do_line(0, 0, 0, 0, 24'hFF00FF, 2);
      // short line at the grid corner, walking left and down
      do_line(CMAX, 0, CMAX - 2, 3, 24'h00FF00, 4);
      // vertical and horizontal lines include their end point
      do_line(0, CMAX, 0, CMAX - 2, 24'h807F01, 3);
      do_line(CMAX - 2, 7, CMAX, 7, 24'h010203, 3);
      // full diagonal, dropped by the next load
      do_line(0, 0, CMAX, CMAX, 24'hFFFFFF, 2);
      // extreme shallow and steep lines drive the error term to its limits
      do_line(CMAX, 1, 0, 0, 24'h000000, 2);
      do_line(1, 0, 0, CMAX, 24'h55AA55, 2);

      while (items_sent < ITEM_GOAL) begin
         pick = int'($urandom_range(99));
         if (pick < 75) begin
            // short line walked to the end, sometimes past it or cut short
            sx    = int'($urandom_range(CMAX));
            sy    = int'($urandom_range(CMAX));
            ex    = near_coord(sx, int'($urandom_range(12)));
            ey    = near_coord(sy, int'($urandom_range(12)));
            len   = (ex > sx ? ex - sx : sx - ex);
            if ((ey > sy ? ey - sy : sy - ey) > len)
               len = (ey > sy ? ey - sy : sy - ey);
            steps = len + 1;
            tweak = int'($urandom_range(9));
            if (tweak == 0)
               steps += int'($urandom_range(1, 3));
            else if (tweak == 1)
               steps = int'($urandom_range(1, steps));
            do_line(sx, sy, ex, ey, 24'($urandom), steps);
         end else if (pick < 88) begin
            // long line, interrupted by whatever follows
            do_line(int'($urandom_range(CMAX)), int'($urandom_range(CMAX)),
                    int'($urandom_range(CMAX)), int'($urandom_range(CMAX)),
                    24'($urandom), int'($urandom_range(5, 40)));
         end else begin
            // noise: random kinds and fields
            repeat ($urandom_range(1, 4)) send_beat(random_beat());
         end
      end

      // drop the request, drain the pixels, and hold for late extras
      req_push <= 1'b0;
      pop_stall_pct = 0;
      while (predictor.pending() != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      @(negedge clock);
      if (predictor.mismatches == 0 && predictor.pending() == 0)
         $display("line_rasterizer regression: pass");
      else
         $display("line_rasterizer regression: fail");
      $finish;
   end

endmodule

FILE: line_rasterizer.f
sv/lr_pkg.sv
sv/lr_fifo.sv
sv/lr_front.sv
sv/lr_back.sv
sv/line_rasterizer.sv
verif/testbench.sv
